/* rtl/sgm_pca_pkg.sv */
// shared types and constants for the sgm path cost aggregation block
// no dependencies; used by every module under rtl

package sgm_pca_pkg;

    localparam int MAX_DISP   = 256;
    localparam int DISP_BITS  = $clog2(MAX_DISP);
    localparam int ADDR_BITS  = DISP_BITS + 1;
    localparam int COST_BITS  = 8;
    localparam int PATH_BITS  = 9;
    localparam int PEN_BITS   = 8;
    localparam int COUNT_BITS = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [PATH_BITS-1:0]  PATH_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_DISP);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMALL_PENALTY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LARGE_PENALTY    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISPARITY_COUNT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISPARITY_OFFSET = 2'd3;

    // reset values
    localparam logic [PEN_BITS-1:0]   RST_SMALL_PENALTY    = 8'd10;
    localparam logic [PEN_BITS-1:0]   RST_LARGE_PENALTY    = 8'd30;
    localparam logic [COUNT_BITS-1:0] RST_DISPARITY_COUNT  = 9'd64;
    localparam logic [PEN_BITS-1:0]   RST_DISPARITY_OFFSET = 8'd20;

    typedef struct packed {
        logic [PEN_BITS-1:0]   small_penalty;
        logic [PEN_BITS-1:0]   large_penalty;
        logic [COUNT_BITS-1:0] disparity_count;
        logic [PEN_BITS-1:0]   disparity_offset;
    } cfg_t;

    typedef struct packed {
        logic [PATH_BITS-1:0] best_cost;
        logic [PATH_BITS-1:0] best_disparity;
        logic                 pixel_done;
        logic [PATH_BITS-1:0] path_cost;
    } result_t;

endpackage

/* rtl/sgm_path_cost_aggregation.sv */
// sgm path cost aggregation top level: config registers, datapath, result buffer
// depends on sgm_pca_pkg, sgm_pca_datapath and sgm_pca_out_buf
//
// usage:
//   s_ channel carries one matching cost per request, all disparities of a
//   pixel in order, pixel after pixel along the scan line; s_tuser is high
//   for every cost of the first pixel of a line.
//   m_ channel returns one result per request in the same order; m_tlast
//   marks the last disparity of a pixel, where tdata also holds the pixel's
//   best disparity (offset plus index of the first minimum) and its cost.
//   the cfg_ port writes a register on any cycle with cfg_wr_en high; write
//   only while no request is in flight.
// timing:
//   one request a cycle sustained while m_tready stays high; a result is
//   registered in the result buffer before it is visible on m_. the previous
//   pixel's costs sit in a 512 x 9 cost memory read one entry ahead of the
//   current disparity, so a new request can follow every cycle.
// reset: counters, minima and bank select clear, registers take their
//   defaults; the first pixel after reset must carry s_tuser high.
// stall: a two-entry result buffer holds results while m_tready is low and
//   s_tready drops once both entries are full.

module sgm_path_cost_aggregation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] match_cost
    input  logic        s_tuser,     // [0] line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [8:0] path_cost, [17:9] best_disparity,
                                     // [26:18] best_cost, rest zero
    output logic        m_tlast,     // pixel_done
    input  logic        cfg_wr_en,
    input  logic [sgm_pca_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sgm_pca_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    sgm_pca_pkg::cfg_t    cfg_reg, cfg_next;
    sgm_pca_pkg::result_t dp_result;
    sgm_pca_pkg::result_t buf_data;
    logic                 in_accept;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                sgm_pca_pkg::CFG_SMALL_PENALTY:
                    cfg_next.small_penalty = cfg_wdata[sgm_pca_pkg::PEN_BITS-1:0];
                sgm_pca_pkg::CFG_LARGE_PENALTY:
                    cfg_next.large_penalty = cfg_wdata[sgm_pca_pkg::PEN_BITS-1:0];
                sgm_pca_pkg::CFG_DISPARITY_COUNT:
                    cfg_next.disparity_count = cfg_wdata;
                sgm_pca_pkg::CFG_DISPARITY_OFFSET:
                    cfg_next.disparity_offset = cfg_wdata[sgm_pca_pkg::PEN_BITS-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.small_penalty    <= sgm_pca_pkg::RST_SMALL_PENALTY;
            cfg_reg.large_penalty    <= sgm_pca_pkg::RST_LARGE_PENALTY;
            cfg_reg.disparity_count  <= sgm_pca_pkg::RST_DISPARITY_COUNT;
            cfg_reg.disparity_offset <= sgm_pca_pkg::RST_DISPARITY_OFFSET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_accept = s_tvalid && s_tready;

    sgm_pca_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_accept  (in_accept),
        .match_cost (s_tdata),
        .line_start (s_tuser),
        .result     (dp_result)
    );

    sgm_pca_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_accept),
        .wr_data  (dp_result),
        .wr_ready (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (buf_data)
    );

    assign m_tdata = {5'b0, buf_data.best_cost, buf_data.best_disparity, buf_data.path_cost};
    assign m_tlast = buf_data.pixel_done;

endmodule

/* rtl/sgm_pca_datapath.sv */
// path cost datapath: previous-pixel cost memory, neighbour window and
// per-pixel minimum tracking; uses sgm_pca_pkg

module sgm_pca_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sgm_pca_pkg::cfg_t                cfg,
    input  logic                             in_accept,
    input  logic [sgm_pca_pkg::COST_BITS-1:0] match_cost,
    input  logic                             line_start,
    output sgm_pca_pkg::result_t             result
);

    localparam int PB = sgm_pca_pkg::PATH_BITS;
    localparam int DB = sgm_pca_pkg::DISP_BITS;
    localparam int AB = sgm_pca_pkg::ADDR_BITS;
    localparam int SB = PB + 3;

    // cost memory, two banks of MAX_DISP entries selected by the top address bit
    logic [PB-1:0] cost_mem [0:(1 << AB)-1];

    logic [DB-1:0] cnt_reg, cnt_next;
    logic          bank_reg, bank_next;
    logic [PB-1:0] prev_min_reg, prev_min_next;
    logic [PB-1:0] run_min_reg, run_min_next;
    logic [DB-1:0] run_idx_reg, run_idx_next;
    logic [PB-1:0] w_lo_reg, w_lo_next;
    logic [PB-1:0] w_mid_reg, w_mid_next;
    logic [PB-1:0] first_reg, first_next;
    logic [PB-1:0] ram_q_reg;
    logic          hit_reg;
    logic [PB-1:0] byp_reg;

    logic [sgm_pca_pkg::COUNT_BITS-1:0] count_eff;
    logic          done;
    logic [PB-1:0] p_hi;
    logic [PB:0]   t_large, t_mid, t_lo, t_hi, best;
    logic signed [SB-1:0] raw;
    logic [PB-1:0] path;
    logic          better;
    logic [PB-1:0] new_min;
    logic [DB-1:0] new_idx;
    logic [AB-1:0] waddr, raddr;

    always_comb begin
        if (cfg.disparity_count == '0) begin
            count_eff = sgm_pca_pkg::COUNT_BITS'(1);
        end else if (cfg.disparity_count > sgm_pca_pkg::COUNT_MAX) begin
            count_eff = sgm_pca_pkg::COUNT_MAX;
        end else begin
            count_eff = cfg.disparity_count;
        end
    end

    assign done = ({1'b0, cnt_reg} + 9'd1) >= count_eff;

    // upper neighbour comes from the memory, with same-cycle write bypass
    assign p_hi = hit_reg ? byp_reg : ram_q_reg;

    always_comb begin
        t_large = {1'b0, prev_min_reg} + {2'b0, cfg.large_penalty};
        t_mid   = {1'b0, w_mid_reg};
        t_lo    = {1'b0, w_lo_reg} + {2'b0, cfg.small_penalty};
        t_hi    = {1'b0, p_hi} + {2'b0, cfg.small_penalty};
        best    = t_large;
        if (t_mid < best) begin
            best = t_mid;
        end
        if (cnt_reg != '0 && t_lo < best) begin
            best = t_lo;
        end
        if (!done && t_hi < best) begin
            best = t_hi;
        end
        raw = $signed({{(SB-sgm_pca_pkg::COST_BITS){1'b0}}, match_cost})
            + $signed({{(SB-PB-1){1'b0}}, best})
            - $signed({{(SB-PB){1'b0}}, prev_min_reg});
        if (line_start) begin
            path = PB'(match_cost);
        end else if (raw < 0) begin
            path = '0;
        end else if (raw > $signed({{(SB-PB){1'b0}}, sgm_pca_pkg::PATH_MAX})) begin
            path = sgm_pca_pkg::PATH_MAX;
        end else begin
            path = raw[PB-1:0];
        end
    end

    assign better  = path < run_min_reg;
    assign new_min = better ? path : run_min_reg;
    assign new_idx = better ? cnt_reg : run_idx_reg;

    always_comb begin
        result.path_cost      = path;
        result.pixel_done     = done;
        result.best_disparity = '0;
        result.best_cost      = '0;
        if (done) begin
            result.best_disparity = {1'b0, cfg.disparity_offset} + {1'b0, new_idx};
            result.best_cost      = new_min;
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        bank_next     = bank_reg;
        prev_min_next = prev_min_reg;
        run_min_next  = run_min_reg;
        run_idx_next  = run_idx_reg;
        w_lo_next     = w_lo_reg;
        w_mid_next    = w_mid_reg;
        first_next    = first_reg;
        if (in_accept) begin
            if (cnt_reg == '0) begin
                first_next = path;
            end
            if (done) begin
                cnt_next      = '0;
                bank_next     = ~bank_reg;
                prev_min_next = new_min;
                run_min_next  = sgm_pca_pkg::PATH_MAX;
                run_idx_next  = '0;
                w_lo_next     = w_mid_reg;
                // disparity zero of the next pixel sees this pixel's first cost
                w_mid_next    = (cnt_reg == '0) ? path : first_reg;
            end else begin
                cnt_next      = cnt_reg + 1'b1;
                run_min_next  = new_min;
                run_idx_next  = new_idx;
                w_lo_next     = w_mid_reg;
                w_mid_next    = p_hi;
            end
        end
    end

    // write the current bank, read one entry ahead in the previous bank
    assign waddr = {bank_reg, cnt_reg};
    assign raddr = {~bank_next, cnt_next + 1'b1};

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cost_mem[waddr] <= path;
        end
        ram_q_reg <= cost_mem[raddr];
        hit_reg   <= in_accept && (waddr == raddr);
        byp_reg   <= path;
        w_lo_reg  <= w_lo_next;
        w_mid_reg <= w_mid_next;
        first_reg <= first_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            prev_min_reg <= '0;
            run_min_reg  <= sgm_pca_pkg::PATH_MAX;
            run_idx_reg  <= '0;
        end else begin
            cnt_reg      <= cnt_next;
            bank_reg     <= bank_next;
            prev_min_reg <= prev_min_next;
            run_min_reg  <= run_min_next;
            run_idx_reg  <= run_idx_next;
        end
    end

    a_cnt_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && done |=> cnt_reg == '0 && run_min_reg == sgm_pca_pkg::PATH_MAX)
        else $error("disparity counter not cleared at end of pixel");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !done |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("disparity counter did not advance");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> bank_reg == ($past(bank_reg) ^ $past(done)))
        else $error("bank select out of step with pixel end");

    a_best_le_path: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && done |-> result.best_cost <= result.path_cost)
        else $error("pixel minimum above its last path cost");

endmodule

/* rtl/sgm_pca_out_buf.sv */
// two-entry result buffer between the datapath and the output channel
// uses sgm_pca_pkg::result_t

module sgm_pca_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  sgm_pca_pkg::result_t wr_data,
    output logic                 wr_ready,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output sgm_pca_pkg::result_t rd_data
);

    sgm_pca_pkg::result_t entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       pop;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, wr_en} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> fill_reg != 2'd2)
        else $error("write into full result buffer");

    a_fill_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer fill level disagrees with pointers");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("buffer fill level out of range");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for sgm_path_cost_aggregation: directed and random cost streams
// with random idling on both channels, checked against an in-bench path cost predictor
// depends on sgm_pca_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] match_cost
    logic        s_tuser   = 1'b0; // [0] line_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [8:0] path_cost, [17:9] best_disparity, [26:18] best_cost
    logic        m_tlast;          // pixel_done
    logic        cfg_wr_en = 1'b0;
    logic [sgm_pca_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [sgm_pca_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    sgm_path_cost_aggregation u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    sgm_pca_pkg::cfg_t                 cfg_copy;
    logic [sgm_pca_pkg::PATH_BITS-1:0] cost_bank [2][sgm_pca_pkg::MAX_DISP];
    bit                                entry_written [2][sgm_pca_pkg::MAX_DISP];
    logic [sgm_pca_pkg::PATH_BITS-1:0] prev_min;
    logic [sgm_pca_pkg::PATH_BITS-1:0] run_min;
    logic [sgm_pca_pkg::DISP_BITS-1:0] run_idx;
    int                                disp_ctr;
    bit                                bank_sel;

    sgm_pca_pkg::result_t expected_paths [$];
    int      errors = 0;
    logic    calm = 1'b0;
    int      hold_ticket = 0;

    task automatic reset_model();
        cfg_copy.small_penalty    = sgm_pca_pkg::RST_SMALL_PENALTY;
        cfg_copy.large_penalty    = sgm_pca_pkg::RST_LARGE_PENALTY;
        cfg_copy.disparity_count  = sgm_pca_pkg::RST_DISPARITY_COUNT;
        cfg_copy.disparity_offset = sgm_pca_pkg::RST_DISPARITY_OFFSET;
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < sgm_pca_pkg::MAX_DISP; i++) begin
                cost_bank[b][i]     = '0;
                entry_written[b][i] = 1'b0;
            end
        end
        prev_min = '0;
        run_min  = sgm_pca_pkg::PATH_MAX;
        run_idx  = '0;
        disp_ctr = 0;
        bank_sel = 1'b0;
    endtask

    function automatic int eff_count();
        if (cfg_copy.disparity_count == 0)
            return 1;
        if (cfg_copy.disparity_count > sgm_pca_pkg::MAX_DISP)
            return sgm_pca_pkg::MAX_DISP;
        return int'(cfg_copy.disparity_count);
    endfunction

    // true when every previous-pixel entry the next non-first cost reads has been written
    function automatic bit reads_are_written();
        int d;
        int cnt;
        d   = (disp_ctr >= sgm_pca_pkg::MAX_DISP) ? sgm_pca_pkg::MAX_DISP - 1 : disp_ctr;
        cnt = eff_count();
        if (!entry_written[bank_sel][d])
            return 1'b0;
        if (d > 0 && !entry_written[bank_sel][d-1])
            return 1'b0;
        if (d + 1 < cnt && !entry_written[bank_sel][d+1])
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic sgm_pca_pkg::result_t aggregate_cost(input logic [7:0] cost,
                                                            input logic first);
        sgm_pca_pkg::result_t r;
        int      cnt;
        int      d;
        int      best;
        int      t;
        int      pm;
        int      p1;
        int      val;
        bit      wr;
        cnt = eff_count();
        d   = (disp_ctr >= sgm_pca_pkg::MAX_DISP) ? sgm_pca_pkg::MAX_DISP - 1 : disp_ctr;
        wr  = !bank_sel;
        if (first) begin
            val = int'(cost);
        end else begin
            pm   = int'(prev_min);
            p1   = int'(cfg_copy.small_penalty);
            best = pm + int'(cfg_copy.large_penalty);
            t    = int'(cost_bank[bank_sel][d]);
            if (t < best) best = t;
            if (d > 0) begin
                t = int'(cost_bank[bank_sel][d-1]) + p1;
                if (t < best) best = t;
            end
            if (d + 1 < cnt) begin
                t = int'(cost_bank[bank_sel][d+1]) + p1;
                if (t < best) best = t;
            end
            val = int'(cost) + best - pm;
        end
        if (val < 0) val = 0;
        if (val > int'(sgm_pca_pkg::PATH_MAX)) val = int'(sgm_pca_pkg::PATH_MAX);

        cost_bank[wr][d]     = 9'(val);
        entry_written[wr][d] = 1'b1;
        if (val < int'(run_min)) begin
            run_min = 9'(val);
            run_idx = 8'(d);
        end

        r            = '0;
        r.path_cost  = 9'(val);
        r.pixel_done = (d + 1 >= cnt);
        if (r.pixel_done) begin
            r.best_disparity = {1'b0, cfg_copy.disparity_offset} + {1'b0, run_idx};
            r.best_cost      = run_min;
            prev_min = run_min;
            run_min  = sgm_pca_pkg::PATH_MAX;
            run_idx  = '0;
            disp_ctr = 0;
            bank_sel = !bank_sel;
        end else begin
            disp_ctr = d + 1;
        end
        return r;
    endfunction

    // one cost request; a non-first cost whose neighbours were never written goes as first
    task automatic send_cost(input logic [7:0] cost, input logic first);
        logic                 ls;
        sgm_pca_pkg::result_t exp_r;
        ls = first;
        if (!ls && !reads_are_written())
            ls = 1'b1;
        if (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cost;
        s_tuser  <= ls;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_r = aggregate_cost(cost, ls);
        expected_paths.insert(expected_paths.size(), exp_r);
    endtask

    task automatic send_pixel(input bit first_of_line);
        int         n;
        logic       ls;
        logic [7:0] c;
        n = eff_count();
        for (int i = 0; i < n; i++) begin
            ls = first_of_line;
            if ($urandom_range(99) < 4)
                ls = !ls;
            case ($urandom_range(9))
                0:       c = 8'd0;
                1:       c = 8'd255;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_cost(c, ls);
        end
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (expected_paths.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sgm_pca_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [sgm_pca_pkg::CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            sgm_pca_pkg::CFG_SMALL_PENALTY:
                cfg_copy.small_penalty = value[sgm_pca_pkg::PEN_BITS-1:0];
            sgm_pca_pkg::CFG_LARGE_PENALTY:
                cfg_copy.large_penalty = value[sgm_pca_pkg::PEN_BITS-1:0];
            sgm_pca_pkg::CFG_DISPARITY_COUNT:
                cfg_copy.disparity_count = value;
            sgm_pca_pkg::CFG_DISPARITY_OFFSET:
                cfg_copy.disparity_offset = value[sgm_pca_pkg::PEN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] p1, input logic [7:0] p2,
                              input logic [8:0] cnt, input logic [7:0] offs);
        wait_results();
        write_reg(sgm_pca_pkg::CFG_SMALL_PENALTY, {1'b0, p1});
        write_reg(sgm_pca_pkg::CFG_LARGE_PENALTY, {1'b0, p2});
        write_reg(sgm_pca_pkg::CFG_DISPARITY_COUNT, cnt);
        write_reg(sgm_pca_pkg::CFG_DISPARITY_OFFSET, {1'b0, offs});
        cfg_wr_en <= 1'b0;
    endtask

    // penalties and offset keep their reset values, only the count is shortened
    task automatic test_reset_values();
        write_reg(sgm_pca_pkg::CFG_DISPARITY_COUNT, 9'd4);
        cfg_wr_en <= 1'b0;
        send_cost(8'd0, 1'b1);
        send_cost(8'd255, 1'b1);
        send_cost(8'd17, 1'b1);
        send_cost(8'd200, 1'b1);
        send_cost(8'd255, 1'b0);
        send_cost(8'd0, 1'b0);
        send_cost(8'd90, 1'b0);
        send_cost(8'd3, 1'b0);
    endtask

    // pixel cut short when the count drops to the number of disparities already taken
    task automatic test_count_change_mid_pixel();
        set_config(8'd10, 8'd30, 9'd6, 8'd5);
        send_cost(8'd80, 1'b1);
        send_cost(8'd12, 1'b1);
        set_config(8'd10, 8'd30, 9'd2, 8'd5);
        send_cost(8'd40, 1'b1);
    endtask

    // a count of zero behaves as one disparity per pixel
    task automatic test_count_zero();
        set_config(8'd3, 8'd7, 9'd0, 8'd9);
        send_cost(8'd40, 1'b1);
        send_cost(8'd255, 1'b0);
        send_cost(8'd0, 1'b0);
    endtask

    // stale low costs left from an older pixel push the path cost below zero
    task automatic test_saturation();
        set_config(8'd0, 8'd255, 9'd4, 8'd0);
        repeat (4) send_cost(8'd0, 1'b1);
        repeat (4) send_cost(8'd200, 1'b1);
        set_config(8'd0, 8'd255, 9'd1, 8'd0);
        send_cost(8'd250, 1'b1);
        set_config(8'd0, 8'd255, 9'd4, 8'd0);
        repeat (4) send_cost(8'd0, 1'b0);
    endtask

    // receiver holds off long enough to fill the result buffer, then the sender pauses
    task automatic test_output_stall();
        set_config(8'd4, 8'd60, 9'd5, 8'd100);
        hold_ticket <= hold_ticket + 1;
        send_pixel(1'b1);
        repeat (4) send_pixel(1'b0);
        wait_results();
        repeat (2) send_pixel(1'b0);
    endtask

    task automatic test_random_lines();
        int         sent;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] offs;
        logic [8:0] cnt;
        bit         first;
        for (int phase = 0; phase < 6; phase++) begin
            p1 = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                          : 8'($urandom_range(0, 40));
            p2 = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                          : 8'($urandom_range(0, 255));
            offs = ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
            case (phase)
                0:       cnt = 9'd1;
                1:       cnt = 9'd2;
                default: cnt = 9'($urandom_range(3, 16));
            endcase
            set_config(p1, p2, cnt, offs);
            calm <= (phase == 4);
            sent  = 0;
            first = 1'b1;
            while (sent < ((phase == 4) ? 30 : 10)) begin
                send_pixel(first || $urandom_range(99) < 8);
                first = 1'b0;
                sent += eff_count();
                if ($urandom_range(99) < 5)
                    wait_results();
            end
        end
    endtask

    // count beyond the maximum acts as the maximum; largest offset and index
    task automatic test_widest_count();
        set_config(8'($urandom_range(0, 30)), 8'($urandom_range(30, 255)), 9'd511, 8'd255);
        send_pixel(1'b1);
        send_pixel(1'b0);
    endtask

    // result receiver: random stalls, long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 28);
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : result_check
        sgm_pca_pkg::result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_paths.size() == 0) begin
                errors++;
                $display("%0t unexpected result expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                exp_r = expected_paths.pop_front();
                check_field("path_cost", exp_r.path_cost, m_tdata[8:0]);
                check_field("pixel_done", exp_r.pixel_done, m_tlast);
                check_field("best_disparity", exp_r.best_disparity, m_tdata[17:9]);
                check_field("best_cost", exp_r.best_cost, m_tdata[26:18]);
                check_field("unused tdata bits", 0, m_tdata[31:27]);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("sgm_path_cost_aggregation verification failed");
                $finish;
            end
        end
    end

    initial begin
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_count_change_mid_pixel();
        test_count_zero();
        test_saturation();
        test_output_stall();
        test_random_lines();
        test_widest_count();
        wait_results();
        repeat (4) @(posedge aclk);
        if (errors == 0 && expected_paths.size() == 0) begin
            $display("sgm_path_cost_aggregation verification clean");
        end else begin
            $display("sgm_path_cost_aggregation verification failed");
        end
        $finish;
    end

endmodule
